### hdl/tba_pkg.sv
// ----------------------------------------------------------------------------
// tba_pkg
// Shared widths, register indexes and reset values of the time bin averager.
// ----------------------------------------------------------------------------
package tba_pkg;

    localparam int TIME_W          = 63;
    localparam int BIN_WIDTH_W     = 40;
    localparam int CODE_W          = 16;
    localparam int DIV_W           = 64;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_BIN_WIDTH       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_TIME      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_START_ENABLE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_SEVERITY = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_EST_REPEAT_SEV  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SEVERITY_MASK   = 3'd5;

    localparam logic [BIN_WIDTH_W-1:0] BIN_WIDTH_RST  = 40'd1000000000;
    localparam logic [CODE_W-1:0]      REPEAT_SEV_RST = 16'd3856;
    localparam logic [CODE_W-1:0]      EST_REP_RST    = 16'd3968;
    localparam logic [CODE_W-1:0]      SEV_MASK_RST   = 16'd4095;

endpackage

### hdl/tba_if.sv
// ----------------------------------------------------------------------------
// tba_if
// Sample, result and register write channels of the time bin averager.
// ----------------------------------------------------------------------------
interface tba_sample_if #(parameter int VALUE_WIDTH = tba_pkg::VALUE_WIDTH_DEF);
    logic                              valid;
    logic                              ready;
    logic [tba_pkg::TIME_W-1:0]        timestamp;
    logic signed [VALUE_WIDTH-1:0]     value;
    logic [tba_pkg::CODE_W-1:0]        severity;
    logic [tba_pkg::CODE_W-1:0]        status;
    logic                              numeric_scalar;
    logic                              end_of_stream;

    modport source (output valid, timestamp, value, severity, status, numeric_scalar,
                    end_of_stream, input ready);
    modport sink (input valid, timestamp, value, severity, status, numeric_scalar,
                  end_of_stream, output ready);
endinterface

interface tba_result_if #(parameter int VALUE_WIDTH = tba_pkg::VALUE_WIDTH_DEF);
    logic                              valid;
    logic                              ready;
    logic [tba_pkg::TIME_W-1:0]        out_time;
    logic signed [VALUE_WIDTH-1:0]     out_value;
    logic [tba_pkg::CODE_W-1:0]        out_severity;
    logic [tba_pkg::CODE_W-1:0]        out_status;
    logic                              is_raw;
    logic signed [VALUE_WIDTH-1:0]     bin_minimum;
    logic signed [VALUE_WIDTH-1:0]     bin_maximum;
    logic                              last_of_run;

    modport source (output valid, out_time, out_value, out_severity, out_status, is_raw,
                    bin_minimum, bin_maximum, last_of_run, input ready);
    modport sink (input valid, out_time, out_value, out_severity, out_status, is_raw,
                  bin_minimum, bin_maximum, last_of_run, output ready);
endinterface

interface tba_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tba_pkg::CFG_INDEX_W-1:0]   index;
    logic [tba_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hdl/tba_divider.sv
// ----------------------------------------------------------------------------
// tba_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tba_divider (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [tba_pkg::DIV_W-1:0]          dividend,
    input  logic [tba_pkg::BIN_WIDTH_W-1:0]    divisor,
    output logic                               done,
    output logic [tba_pkg::DIV_W-1:0]          quotient,
    output logic [tba_pkg::BIN_WIDTH_W-1:0]    remainder
);
    localparam int N     = tba_pkg::DIV_W;
    localparam int DW    = tba_pkg::BIN_WIDTH_W;
    localparam int CNT_W = $clog2(N + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [N-1:0]     quo_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    den_reg;
    logic [DW+1:0]    trial;
    logic             fits;

    assign trial = {1'b0, rem_reg, quo_reg[N-1]} - {2'b00, den_reg};
    assign fits  = !trial[DW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(N);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[N-2:0], fits};
            rem_reg <= fits ? trial[DW-1:0] : {rem_reg[DW-2:0], quo_reg[N-1]};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### hdl/time_bin_averager_unit.sv
// ----------------------------------------------------------------------------
// time_bin_averager_unit
// Decimates a time-ordered sample stream into fixed-width time bins.
// ----------------------------------------------------------------------------
// Channels: samples (valid/ready) takes one sample per item; results
// (valid/ready) gives zero, one or two result items per sample, the final
// one marked by last_of_run; cfg writes register index/data and is always
// ready. Write cfg only while the block is idle.
// Throughput: one sample at a time; the next sample is taken only once
// the block is back in idle. Each bin realignment and each averaged bin
// runs the shared serial divider, and a realignment then passes through
// the ALN_A, ALN_B and ALN_C states.
// The result register holds one finished item; the next sample is taken
// while it waits. When results stalls, work halts before the next push.
// Reset: registers return to their defaults, no bin is open and the
// block is ready at once.
// ----------------------------------------------------------------------------
module time_bin_averager_unit #(
    parameter int COUNT_WIDTH = tba_pkg::COUNT_WIDTH_DEF,
    parameter int VALUE_WIDTH = tba_pkg::VALUE_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    tba_sample_if.sink   samples,
    tba_result_if.source results,
    tba_cfg_if.sink      cfg
);
    localparam int TW      = tba_pkg::TIME_W;
    localparam int BW      = tba_pkg::BIN_WIDTH_W;
    localparam int CW      = tba_pkg::CODE_W;
    localparam int NW      = tba_pkg::DIV_W;
    localparam int VW      = VALUE_WIDTH;
    localparam int SUM_MAG = (VW + COUNT_WIDTH - 1 > 62) ? 62 : VW + COUNT_WIDTH - 1;
    localparam int SUM_W   = SUM_MAG + 1;
    localparam int EXT_W   = ((SUM_W > VW) ? SUM_W : VW) + 1;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_CLOSE   = 4'd2;
    localparam logic [3:0] S_REALIGN = 4'd3;
    localparam logic [3:0] S_DIV     = 4'd4;
    localparam logic [3:0] S_ALN_A   = 4'd5;
    localparam logic [3:0] S_ALN_B   = 4'd6;
    localparam logic [3:0] S_ALN_C   = 4'd7;
    localparam logic [3:0] S_ACCUM   = 4'd8;
    localparam logic [3:0] S_PUSH1   = 4'd9;
    localparam logic [3:0] S_EOS     = 4'd10;
    localparam logic [3:0] S_PUSH2   = 4'd11;

    localparam logic [1:0] K_ALIGN = 2'd0;
    localparam logic [1:0] K_AVG1  = 2'd1;
    localparam logic [1:0] K_AVG2  = 2'd2;

    // configuration
    logic [BW-1:0]  bin_width_reg;
    logic [TW-1:0]  start_time_reg;
    logic           start_enable_reg;
    logic [CW-1:0]  repeat_sev_reg;
    logic [CW-1:0]  est_repeat_sev_reg;
    logic [CW-1:0]  sev_mask_reg;

    // control and bin state
    logic [3:0]              state_reg, state_next;
    logic [1:0]              kind_reg;
    logic                    started_reg;
    logic [NW-1:0]           bin_end_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [COUNT_WIDTH-1:0]  count_reg;
    logic signed [VW-1:0]    min_reg, max_reg;
    logic [CW-1:0]           best_sev_reg, best_stat_reg;
    logic                    skip_reg;
    logic                    pending_reg;
    logic                    out_valid_reg;

    // payload
    logic [TW-1:0]        t_reg;
    logic signed [VW-1:0] v_reg;
    logic [CW-1:0]        sev_reg, stat_reg;
    logic                 num_reg, eos_reg;
    logic [TW-1:0]        held_time_reg;
    logic signed [VW-1:0] held_value_reg;
    logic [CW-1:0]        held_sev_reg, held_stat_reg;
    logic                 avg_neg_reg;
    logic [TW-1:0]        res_time_reg;
    logic signed [VW-1:0] res_value_reg, res_min_reg, res_max_reg;
    logic [CW-1:0]        res_sev_reg, res_stat_reg;
    logic                 res_raw_reg;
    logic [TW-1:0]        out_time_reg;
    logic signed [VW-1:0] out_value_reg, out_min_reg, out_max_reg;
    logic [CW-1:0]        out_sev_reg, out_stat_reg;
    logic                 out_raw_reg, out_last_reg;

    // datapath
    logic [BW-1:0]           w_eff, half;
    logic [NW-1:0]           half_x, w_x, center;
    logic                    past_end, before_start;
    logic                    count_zero, count_one, count_many, counted;
    logic                    sum_neg;
    logic [SUM_W-1:0]        sum_mag;
    logic signed [EXT_W-1:0] sum_x, v_x, sum_raw, lim_x;
    logic [SUM_W-1:0]        sum_new;
    logic [NW-1:0]           hi64, lo_mag64, neg_q;
    logic signed [VW-1:0]    avg_val;
    logic                    out_free;
    logic                    push;
    logic                    div_start, div_done;
    logic [NW-1:0]           div_dividend, div_quo;
    logic [BW-1:0]           div_divisor, div_rem;

    assign w_eff        = (bin_width_reg == '0) ? BW'(1) : bin_width_reg;
    assign half         = w_eff >> 1;
    assign half_x       = {{(NW-BW){1'b0}}, half};
    assign w_x          = {{(NW-BW){1'b0}}, w_eff};
    assign center       = bin_end_reg - half_x;
    assign past_end     = {1'b0, t_reg} >= bin_end_reg;
    assign before_start = start_enable_reg && (t_reg < start_time_reg);
    assign count_zero   = count_reg == '0;
    assign count_one    = count_reg == COUNT_WIDTH'(1);
    assign count_many   = !count_zero && !count_one;
    assign counted      = num_reg && (sev_reg != repeat_sev_reg)
                          && (sev_reg != est_repeat_sev_reg) && !(&count_reg);
    assign sum_neg      = sum_reg[SUM_W-1];
    assign sum_mag      = sum_neg ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    assign sum_x   = {{(EXT_W-SUM_W){sum_reg[SUM_W-1]}}, sum_reg};
    assign v_x     = {{(EXT_W-VW){v_reg[VW-1]}}, v_reg};
    assign sum_raw = sum_x + v_x;
    assign lim_x   = {{(EXT_W-SUM_MAG){1'b0}}, {SUM_MAG{1'b1}}};

    always_comb
    begin
        if (sum_raw > lim_x)
            sum_new = lim_x[SUM_W-1:0];
        else if (sum_raw < -lim_x)
            sum_new = SUM_W'(-lim_x);
        else
            sum_new = sum_raw[SUM_W-1:0];
    end

    assign hi64     = {{(NW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    assign lo_mag64 = hi64 + NW'(1);
    assign neg_q    = ~div_quo + NW'(1);

    always_comb
    begin
        if (avg_neg_reg)
            avg_val = (div_quo > lo_mag64) ? {1'b1, {(VW-1){1'b0}}} : neg_q[VW-1:0];
        else
            avg_val = (div_quo > hi64) ? hi64[VW-1:0] : div_quo[VW-1:0];
    end

    assign out_free = !out_valid_reg || results.ready;
    assign push     = (state_reg == S_PUSH1 && pending_reg && out_free)
                      || (state_reg == S_PUSH2 && out_free);

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = {1'b0, t_reg};
        div_divisor  = w_eff;
        case (state_reg)
            S_CHECK:   div_start = !started_reg && !before_start && !start_enable_reg;
            S_REALIGN: div_start = past_end;
            S_CLOSE, S_EOS:
            begin
                div_start    = count_many && (state_reg == S_CLOSE || eos_reg);
                div_dividend = {{(NW-SUM_W){1'b0}}, sum_mag};
                div_divisor  = {{(BW-COUNT_WIDTH){1'b0}}, count_reg};
            end
            default: div_start = 1'b0;
        endcase
    end

    tba_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (samples.valid)
                    state_next = S_CHECK;
            S_CHECK:
                if (!started_reg)
                begin
                    if (before_start)
                        state_next = S_IDLE;
                    else if (start_enable_reg)
                        state_next = S_REALIGN;
                    else
                        state_next = S_DIV;
                end
                else
                    state_next = past_end ? S_CLOSE : S_ACCUM;
            S_CLOSE:   state_next = count_many ? S_DIV : S_REALIGN;
            S_REALIGN: state_next = past_end ? S_DIV : S_ACCUM;
            S_DIV:
                if (div_done)
                begin
                    case (kind_reg)
                        K_ALIGN: state_next = S_ALN_A;
                        K_AVG1:  state_next = S_REALIGN;
                        default: state_next = S_PUSH2;
                    endcase
                end
            S_ALN_A:   state_next = S_ALN_B;
            S_ALN_B:   state_next = S_ALN_C;
            S_ALN_C:   state_next = S_ACCUM;
            S_ACCUM:   state_next = S_PUSH1;
            S_PUSH1:
                if (!pending_reg || out_free)
                    state_next = S_EOS;
            S_EOS:
                if (eos_reg && !count_zero)
                    state_next = count_many ? S_DIV : S_PUSH2;
                else
                    state_next = S_IDLE;
            S_PUSH2:
                if (out_free)
                    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_width_reg      <= tba_pkg::BIN_WIDTH_RST;
            start_time_reg     <= '0;
            start_enable_reg   <= 1'b0;
            repeat_sev_reg     <= tba_pkg::REPEAT_SEV_RST;
            est_repeat_sev_reg <= tba_pkg::EST_REP_RST;
            sev_mask_reg       <= tba_pkg::SEV_MASK_RST;
            state_reg          <= S_IDLE;
            kind_reg           <= K_ALIGN;
            started_reg        <= 1'b0;
            bin_end_reg        <= '0;
            sum_reg            <= '0;
            count_reg          <= '0;
            min_reg            <= '0;
            max_reg            <= '0;
            best_sev_reg       <= '0;
            best_stat_reg      <= '0;
            skip_reg           <= 1'b0;
            pending_reg        <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    tba_pkg::REG_BIN_WIDTH:       bin_width_reg      <= cfg.data[BW-1:0];
                    tba_pkg::REG_START_TIME:      start_time_reg     <= cfg.data[TW-1:0];
                    tba_pkg::REG_START_ENABLE:    start_enable_reg   <= cfg.data[0];
                    tba_pkg::REG_REPEAT_SEVERITY: repeat_sev_reg     <= cfg.data[CW-1:0];
                    tba_pkg::REG_EST_REPEAT_SEV:  est_repeat_sev_reg <= cfg.data[CW-1:0];
                    tba_pkg::REG_SEVERITY_MASK:   sev_mask_reg       <= cfg.data[CW-1:0];
                    default: ;
                endcase
            end

            state_reg <= state_next;

            if (push)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_CHECK:
                    if (!started_reg)
                    begin
                        if (!before_start)
                        begin
                            started_reg   <= 1'b1;
                            sum_reg       <= '0;
                            count_reg     <= '0;
                            best_sev_reg  <= '0;
                            best_stat_reg <= '0;
                            skip_reg      <= 1'b0;
                            kind_reg      <= K_ALIGN;
                            if (start_enable_reg)
                                bin_end_reg <= {1'b0, start_time_reg} + half_x;
                        end
                    end
                S_CLOSE:
                begin
                    if (!count_zero)
                    begin
                        pending_reg <= 1'b1;
                        bin_end_reg <= bin_end_reg + w_x;
                    end
                    kind_reg      <= K_AVG1;
                    sum_reg       <= '0;
                    count_reg     <= '0;
                    best_sev_reg  <= '0;
                    best_stat_reg <= '0;
                    skip_reg      <= 1'b0;
                end
                S_REALIGN:
                    kind_reg <= K_ALIGN;
                S_ALN_A:
                    bin_end_reg <= {1'b0, t_reg} - {{(NW-BW){1'b0}}, div_rem};
                S_ALN_B:
                    if (div_rem != '0)
                        bin_end_reg <= bin_end_reg + w_x;
                S_ALN_C:
                    bin_end_reg <= bin_end_reg + half_x;
                S_ACCUM:
                    if (!skip_reg)
                    begin
                        if (!num_reg)
                        begin
                            count_reg <= COUNT_WIDTH'(1);
                            skip_reg  <= 1'b1;
                        end
                        else if (counted)
                        begin
                            sum_reg   <= sum_new;
                            count_reg <= count_reg + COUNT_WIDTH'(1);
                            if ((sev_reg & sev_mask_reg) > best_sev_reg)
                            begin
                                best_sev_reg  <= sev_reg;
                                best_stat_reg <= stat_reg;
                            end
                            if (count_zero || v_reg < min_reg)
                                min_reg <= v_reg;
                            if (count_zero || v_reg > max_reg)
                                max_reg <= v_reg;
                        end
                    end
                S_PUSH1:
                    if (pending_reg && out_free)
                        pending_reg <= 1'b0;
                S_EOS:
                    if (eos_reg)
                    begin
                        started_reg   <= 1'b0;
                        kind_reg      <= K_AVG2;
                        sum_reg       <= '0;
                        count_reg     <= '0;
                        best_sev_reg  <= '0;
                        best_stat_reg <= '0;
                        skip_reg      <= 1'b0;
                    end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                t_reg    <= samples.timestamp;
                v_reg    <= samples.value;
                sev_reg  <= samples.severity;
                stat_reg <= samples.status;
                num_reg  <= samples.numeric_scalar;
                eos_reg  <= samples.end_of_stream;
            end
            S_CLOSE, S_EOS:
            begin
                avg_neg_reg   <= sum_neg;
                res_time_reg  <= count_one ? held_time_reg : center[TW-1:0];
                res_value_reg <= held_value_reg;
                res_sev_reg   <= count_one ? held_sev_reg : best_sev_reg;
                res_stat_reg  <= count_one ? held_stat_reg : best_stat_reg;
                res_raw_reg   <= count_one;
                res_min_reg   <= count_one ? '0 : min_reg;
                res_max_reg   <= count_one ? '0 : max_reg;
            end
            S_DIV:
                if (div_done && kind_reg != K_ALIGN)
                    res_value_reg <= avg_val;
            S_ACCUM:
                if (!skip_reg)
                begin
                    held_time_reg  <= t_reg;
                    held_value_reg <= v_reg;
                    held_sev_reg   <= sev_reg;
                    held_stat_reg  <= stat_reg;
                end
            default: ;
        endcase

        if (push)
        begin
            out_time_reg  <= res_time_reg;
            out_value_reg <= res_value_reg;
            out_sev_reg   <= res_sev_reg;
            out_stat_reg  <= res_stat_reg;
            out_raw_reg   <= res_raw_reg;
            out_min_reg   <= res_min_reg;
            out_max_reg   <= res_max_reg;
            out_last_reg  <= (state_reg == S_PUSH2) || !(eos_reg && !count_zero);
        end
    end

    assign samples.ready        = state_reg == S_IDLE;
    assign cfg.ready            = 1'b1;
    assign results.valid        = out_valid_reg;
    assign results.out_time     = out_time_reg;
    assign results.out_value    = out_value_reg;
    assign results.out_severity = out_sev_reg;
    assign results.out_status   = out_stat_reg;
    assign results.is_raw       = out_raw_reg;
    assign results.bin_minimum  = out_min_reg;
    assign results.bin_maximum  = out_max_reg;
    assign results.last_of_run  = out_last_reg;

endmodule

### hdl/tba_checker.sv
// ----------------------------------------------------------------------------
// tba_checker
// Port-level checks of the time bin averager, bound to its top level.
// ----------------------------------------------------------------------------
module tba_checker #(
    parameter int VALUE_WIDTH = tba_pkg::VALUE_WIDTH_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          samples_valid,
    input logic                          samples_ready,
    input logic                          results_valid,
    input logic                          results_ready,
    input logic [tba_pkg::TIME_W-1:0]    results_time,
    input logic [VALUE_WIDTH-1:0]        results_value,
    input logic                          results_raw,
    input logic [VALUE_WIDTH-1:0]        results_min,
    input logic [VALUE_WIDTH-1:0]        results_max
);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        results_valid && !results_ready |=>
            results_valid && $stable(results_time) && $stable(results_value))
        else $error("result item changed while stalled");

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !results_valid)
        else $error("result valid during reset");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        samples_valid && samples_ready |=> !samples_ready)
        else $error("sample taken while previous one is in work");

    a_raw_no_range: assert property (@(posedge clk) disable iff (!rst_n)
        results_valid && results_raw |-> results_min == '0 && results_max == '0)
        else $error("raw item carries a bin range");

endmodule

bind time_bin_averager_unit tba_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .samples_valid (samples.valid),
    .samples_ready (samples.ready),
    .results_valid (results.valid),
    .results_ready (results.ready),
    .results_time  (results.out_time),
    .results_value (results.out_value),
    .results_raw   (results.is_raw),
    .results_min   (results.bin_minimum),
    .results_max   (results.bin_maximum)
);
